[design/pgs_pkg.sv]
package pgs_pkg;

   localparam int DataWidth   = 16;
   localparam int SqWidth     = 30;
   localparam int LogSteps    = 16;
   localparam int DivSteps    = 30;
   localparam int RootSteps   = 19;

   localparam int QueueDepthDefault = 4;
   localparam int OutDepthDefault   = 4;

   // -log2 of one in Q16 is 30 << 16 for a value scaled by 2^30.
   localparam logic [20:0] LogOfOne    = 21'd1966080;
   // round(2 ln2 * 2^30)
   localparam logic [30:0] Ln2Times2   = 31'd1488522236;

   localparam logic [15:0] MeanReset   = 16'd0;
   localparam logic [15:0] ScaleReset  = 16'd2048;

   typedef enum logic [0:0] {
      CSR_MEAN_OFFSET     = 1'b0,
      CSR_DEVIATION_SCALE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic sign;
      logic last;
   } tag_type;

   typedef struct packed {
      logic        sign_u;
      logic        sign_v;
      logic [29:0] u_sq;
      logic [29:0] v_sq;
      logic [29:0] s_sum;
   } pair_type;

   typedef struct packed {
      logic [15:0] sample;
      logic        last;
      logic        clipped;
   } result_type;

endpackage

[design/pgs_fifo.sv]
module pgs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full      = count_ff == CntW'(DEPTH);
      empty     = count_ff == '0;
      do_push   = push && !full;
      do_pop    = pop && !empty;
      head_data = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/pgs_front.sv]
module pgs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [15:0]        uniform_first,
   input  logic [15:0]        uniform_second,
   output logic               full,
   output logic               q_push,
   output pgs_pkg::pair_type  q_data,
   input  logic               q_full
);

   logic        valid_ff, valid_in;
   logic        sign_u_ff, sign_v_ff;
   logic [30:0] u_sq_ff, v_sq_ff;
   logic [15:0] abs_u, abs_v;
   logic [31:0] prod_u, prod_v;
   logic [31:0] s_sum;
   logic        accepted, stall;

   always_comb begin
      abs_u    = uniform_first[15] ? (~uniform_first + 16'd1) : uniform_first;
      abs_v    = uniform_second[15] ? (~uniform_second + 16'd1) : uniform_second;
      prod_u   = abs_u * abs_u;
      prod_v   = abs_v * abs_v;
      s_sum    = 32'(u_sq_ff) + 32'(v_sq_ff);
      // The pair is usable only when s lies strictly inside the unit circle.
      accepted = (s_sum != '0) && (s_sum[31:30] == 2'b00);
      stall    = valid_ff && accepted && q_full;
      full     = stall;
      valid_in = stall || push;
      q_push   = valid_ff && accepted && !q_full;
      q_data.sign_u = sign_u_ff;
      q_data.sign_v = sign_v_ff;
      q_data.u_sq   = u_sq_ff[29:0];
      q_data.v_sq   = v_sq_ff[29:0];
      q_data.s_sum  = s_sum[29:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         sign_u_ff <= uniform_first[15];
         sign_v_ff <= uniform_second[15];
         u_sq_ff   <= prod_u[30:0];
         v_sq_ff   <= prod_v[30:0];
      end
   end

endmodule

[design/pgs_back.sv]
module pgs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  pgs_pkg::pair_type    q_data,
   output logic                 q_pop,
   input  logic [15:0]          mean_offset,
   input  logic [15:0]          deviation_scale,
   input  logic                 o_full,
   output logic                 o_push,
   output pgs_pkg::result_type  o_data
);

   localparam int LogSteps  = pgs_pkg::LogSteps;
   localparam int DivSteps  = pgs_pkg::DivSteps;
   localparam int RootSteps = pgs_pkg::RootSteps;

   logic adv, issue, sel_ff, sel_in;

   // Issue stage: one sample of the pair per cycle while a pair waits and the result queue has room.
   pgs_pkg::tag_type i_tag_ff, i_tag_in;
   logic [29:0]      i_w2_ff, i_s_ff;

   // Logarithm pipeline; entry 0 holds the normalized mantissa.
   pgs_pkg::tag_type lg_tag_ff  [LogSteps+1];
   logic [29:0]      lg_w2_ff   [LogSteps+1];
   logic [29:0]      lg_s_ff    [LogSteps+1];
   logic [4:0]       lg_int_ff  [LogSteps+1];
   logic [30:0]      lg_m_ff    [LogSteps+1];
   logic [15:0]      lg_frac_ff [LogSteps+1];
   logic [61:0]      lg_sq      [LogSteps];
   logic [30:0]      lg_m_in    [LogSteps];
   logic             lg_bit     [LogSteps];
   logic [4:0]       norm_int;
   logic [30:0]      norm_m;

   pgs_pkg::tag_type dl_tag_ff;
   logic [29:0]      dl_w2_ff, dl_s_ff;
   logic [51:0]      dl_prod_ff;
   logic [20:0]      d_val;

   pgs_pkg::tag_type l_tag_ff;
   logic [29:0]      l_w2_ff, l_s_ff, l_val_ff;
   logic [52:0]      l_round;
   logic [59:0]      num;

   // Restoring division; entry 0 holds the numerator.
   pgs_pkg::tag_type dv_tag_ff [DivSteps+1];
   logic [29:0]      dv_s_ff   [DivSteps+1];
   logic [29:0]      dv_rem_ff [DivSteps+1];
   logic [29:0]      dv_quo_ff [DivSteps+1];
   logic [30:0]      dv_t      [DivSteps];
   logic             dv_ge     [DivSteps];

   // Digit-by-digit square root.
   pgs_pkg::tag_type sq_tag_ff  [RootSteps+1];
   logic [37:0]      sq_x_ff    [RootSteps+1];
   logic [19:0]      sq_rem_ff  [RootSteps+1];
   logic [18:0]      sq_root_ff [RootSteps+1];
   logic [21:0]      sq_r2      [RootSteps];
   logic [21:0]      sq_trial   [RootSteps];
   logic             sq_ge      [RootSteps];

   pgs_pkg::tag_type p_tag_ff, m_tag_ff;
   logic [34:0]      p_prod_ff;
   logic [35:0]      m_round;
   logic [18:0]      m_mag_ff;
   logic signed [20:0] mean_ext, mag_ext, val;

   always_comb begin
      adv      = !o_full;
      issue    = adv && !q_empty;
      q_pop    = issue && sel_ff;
      sel_in   = issue ? ~sel_ff : sel_ff;
      i_tag_in.valid = issue;
      i_tag_in.sign  = sel_ff ? q_data.sign_v : q_data.sign_u;
      i_tag_in.last  = sel_ff;
   end

   always_comb begin
      norm_int = '0;
      for (int k = 0; k < 30; k++) begin
         if (i_s_ff[k]) begin
            norm_int = 5'(k);
         end
      end
      norm_m = 31'(i_s_ff) << (5'd30 - norm_int);
   end

   always_comb begin
      for (int k = 0; k < LogSteps; k++) begin
         lg_sq[k]   = 62'(lg_m_ff[k]) * 62'(lg_m_ff[k]);
         lg_bit[k]  = lg_sq[k][61];
         lg_m_in[k] = lg_bit[k] ? lg_sq[k][61:31] : lg_sq[k][60:30];
      end
      d_val   = pgs_pkg::LogOfOne - {lg_int_ff[LogSteps], lg_frac_ff[LogSteps]};
      l_round = 53'(dl_prod_ff) + 53'(1 << 21);
      num     = 60'(l_w2_ff) * 60'(l_val_ff);
   end

   always_comb begin
      for (int k = 0; k < DivSteps; k++) begin
         dv_t[k]  = {dv_rem_ff[k], dv_quo_ff[k][29]};
         dv_ge[k] = dv_t[k] >= {1'b0, dv_s_ff[k]};
      end
      for (int k = 0; k < RootSteps; k++) begin
         sq_r2[k]    = {sq_rem_ff[k], sq_x_ff[k][37:36]};
         sq_trial[k] = {1'b0, sq_root_ff[k], 2'b01};
         sq_ge[k]    = sq_r2[k] >= sq_trial[k];
      end
   end

   always_comb begin
      m_round  = 36'(p_prod_ff) + 36'(32768);
      mean_ext = 21'(signed'(mean_offset));
      mag_ext  = signed'({2'b00, m_mag_ff});
      val      = m_tag_ff.sign ? (mean_ext - mag_ext) : (mean_ext + mag_ext);
      o_push   = adv && m_tag_ff.valid;
      o_data.last = m_tag_ff.last;
      if (val > 21'sd32767) begin
         o_data.sample  = 16'h7fff;
         o_data.clipped = 1'b1;
      end else if (val < -21'sd32768) begin
         o_data.sample  = 16'h8000;
         o_data.clipped = 1'b1;
      end else begin
         o_data.sample  = val[15:0];
         o_data.clipped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         i_tag_ff <= '0;
         dl_tag_ff <= '0;
         l_tag_ff <= '0;
         p_tag_ff <= '0;
         m_tag_ff <= '0;
         for (int k = 0; k <= LogSteps; k++) begin
            lg_tag_ff[k] <= '0;
         end
         for (int k = 0; k <= DivSteps; k++) begin
            dv_tag_ff[k] <= '0;
         end
         for (int k = 0; k <= RootSteps; k++) begin
            sq_tag_ff[k] <= '0;
         end
      end else begin
         sel_ff <= sel_in;
         if (adv) begin
            i_tag_ff     <= i_tag_in;
            lg_tag_ff[0] <= i_tag_ff;
            for (int k = 0; k < LogSteps; k++) begin
               lg_tag_ff[k+1] <= lg_tag_ff[k];
            end
            dl_tag_ff    <= lg_tag_ff[LogSteps];
            l_tag_ff     <= dl_tag_ff;
            dv_tag_ff[0] <= l_tag_ff;
            for (int k = 0; k < DivSteps; k++) begin
               dv_tag_ff[k+1] <= dv_tag_ff[k];
            end
            sq_tag_ff[0] <= dv_tag_ff[DivSteps];
            for (int k = 0; k < RootSteps; k++) begin
               sq_tag_ff[k+1] <= sq_tag_ff[k];
            end
            p_tag_ff <= sq_tag_ff[RootSteps];
            m_tag_ff <= p_tag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i_w2_ff <= sel_ff ? q_data.v_sq : q_data.u_sq;
         i_s_ff  <= q_data.s_sum;

         lg_w2_ff[0]   <= i_w2_ff;
         lg_s_ff[0]    <= i_s_ff;
         lg_int_ff[0]  <= norm_int;
         lg_m_ff[0]    <= norm_m;
         lg_frac_ff[0] <= '0;
         for (int k = 0; k < LogSteps; k++) begin
            lg_w2_ff[k+1]   <= lg_w2_ff[k];
            lg_s_ff[k+1]    <= lg_s_ff[k];
            lg_int_ff[k+1]  <= lg_int_ff[k];
            lg_m_ff[k+1]    <= lg_m_in[k];
            lg_frac_ff[k+1] <= {lg_frac_ff[k][14:0], lg_bit[k]};
         end

         dl_w2_ff   <= lg_w2_ff[LogSteps];
         dl_s_ff    <= lg_s_ff[LogSteps];
         dl_prod_ff <= 52'(d_val) * 52'(pgs_pkg::Ln2Times2);

         l_w2_ff  <= dl_w2_ff;
         l_s_ff   <= dl_s_ff;
         l_val_ff <= l_round[51:22];

         dv_s_ff[0]   <= l_s_ff;
         dv_rem_ff[0] <= num[59:30];
         dv_quo_ff[0] <= num[29:0];
         for (int k = 0; k < DivSteps; k++) begin
            dv_s_ff[k+1]   <= dv_s_ff[k];
            dv_rem_ff[k+1] <= dv_ge[k] ? 30'(dv_t[k] - {1'b0, dv_s_ff[k]}) : dv_t[k][29:0];
            dv_quo_ff[k+1] <= {dv_quo_ff[k][28:0], dv_ge[k]};
         end

         sq_x_ff[0]    <= {dv_quo_ff[DivSteps], 8'd0};
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         for (int k = 0; k < RootSteps; k++) begin
            sq_x_ff[k+1]    <= {sq_x_ff[k][35:0], 2'b00};
            sq_rem_ff[k+1]  <= sq_ge[k] ? 20'(sq_r2[k] - sq_trial[k]) : sq_r2[k][19:0];
            sq_root_ff[k+1] <= {sq_root_ff[k][17:0], sq_ge[k]};
         end

         p_prod_ff <= 35'(deviation_scale) * 35'(sq_root_ff[RootSteps]);
         m_mag_ff  <= m_round[34:16];
      end
   end

endmodule

[design/polar_gaussian_sampler_top.sv]
// Gaussian noise source built on the polar rejection method.
// Input side: a uniform pair (two signed Q1.15 values) is offered on
// req_uniform_first and req_uniform_second with push; the transaction is taken
// at a clock edge with push high and full low. Pairs on or outside the unit
// circle (or at its center) are dropped and produce nothing.
// Output side: every kept pair yields two transactions in order, the first
// from req_uniform_first and the second, marked by rsp_last_of_pair, from
// req_uniform_second. A result is valid while empty is low and is taken at an
// edge with pop high. rsp_clipped marks a saturated sample.
// The front end takes one pair per cycle while full is low; the back end issues
// one sample per cycle through its log, division and square root pipelines
// while a pair waits and the result queue has room, so a kept pair goes in as
// its two samples and the sustained rate is one result per cycle while popped.
// When the receiver stalls, the output queue fills, the whole back pipeline
// holds, the middle queue fills and full rises; nothing is lost.
// Reset empties both queues and the pipeline, sets mean_offset to 0 and
// deviation_scale to 2048 (one). Write the registers only while idle.
module polar_gaussian_sampler_top #(
   parameter int QUEUE_DEPTH = pgs_pkg::QueueDepthDefault,
   parameter int OUT_DEPTH   = pgs_pkg::OutDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [15:0] req_uniform_first,
   input  logic [15:0] req_uniform_second,
   output logic        full,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_normal_sample,
   output logic        rsp_last_of_pair,
   output logic        rsp_clipped,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   logic [15:0] mean_ff, mean_in;
   logic [15:0] scale_ff, scale_in;

   logic                q_push, q_full, q_pop, q_empty;
   pgs_pkg::pair_type   q_in_data, q_out_data;
   logic                o_push, o_full;
   pgs_pkg::result_type o_in_data, o_out_data;

   // Configuration registers: a write lands in the register its index names.
   always_comb begin
      mean_in  = mean_ff;
      scale_in = scale_ff;
      if (csr_write_enable) begin
         case (pgs_pkg::csr_index_type'(csr_index))
            pgs_pkg::CSR_MEAN_OFFSET:     mean_in  = csr_write_data;
            pgs_pkg::CSR_DEVIATION_SCALE: scale_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff  <= pgs_pkg::MeanReset;
         scale_ff <= pgs_pkg::ScaleReset;
      end else begin
         mean_ff  <= mean_in;
         scale_ff <= scale_in;
      end
   end

   // The front end squares the pair and drops it when it misses the circle.
   pgs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .uniform_first  (req_uniform_first),
      .uniform_second (req_uniform_second),
      .full           (full),
      .q_push         (q_push),
      .q_data         (q_in_data),
      .q_full         (q_full)
   );

   pgs_fifo #(
      .WIDTH ($bits(pgs_pkg::pair_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_pair_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (q_out_data),
      .empty     (q_empty)
   );

   // The back end turns each sample of a kept pair into a scaled gaussian value.
   pgs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_out_data),
      .q_pop           (q_pop),
      .mean_offset     (mean_ff),
      .deviation_scale (scale_ff),
      .o_full          (o_full),
      .o_push          (o_push),
      .o_data          (o_in_data)
   );

   pgs_fifo #(
      .WIDTH ($bits(pgs_pkg::result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data (o_in_data),
      .full      (o_full),
      .pop       (pop),
      .head_data (o_out_data),
      .empty     (empty)
   );

   assign rsp_normal_sample = o_out_data.sample;
   assign rsp_last_of_pair  = o_out_data.last;
   assign rsp_clipped       = o_out_data.clipped;

endmodule

[design/pgs_checker.sv]
module pgs_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [15:0] rsp_normal_sample,
   input logic        rsp_last_of_pair,
   input logic        rsp_clipped
);

   // Reset must leave the result queue drained and the input side ready.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !full)
      else $error("input side still full after reset");

   // A saturated sample can only sit at one of the two range ends.
   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_clipped) |->
         (rsp_normal_sample == 16'h7fff || rsp_normal_sample == 16'h8000))
      else $error("clipped sample is not at a range end");

   // A waiting result holds until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_normal_sample)
         && $stable(rsp_last_of_pair) && $stable(rsp_clipped)))
      else $error("waiting result changed before pop");

endmodule

bind polar_gaussian_sampler_top pgs_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .full              (full),
   .empty             (empty),
   .pop               (pop),
   .rsp_normal_sample (rsp_normal_sample),
   .rsp_last_of_pair  (rsp_last_of_pair),
   .rsp_clipped       (rsp_clipped)
);
